// ----- src/hrcg_pkg.sv -----
// ----------------------------------------------------------------------------
// hrcg_pkg: shared types and constants of the homography remap generator
// Holds the coefficient register format, the register index codes and the
// fixed output formats of the remap table entry.
// ----------------------------------------------------------------------------
package hrcg_pkg;

  // Coefficient registers are signed Q15.24 in 40 bits.
  localparam int CFG_W     = 40;
  localparam int CFG_HALF  = 20;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = 4;
  localparam int ONE_Q24   = 16777216;

  // Input coordinate port width and output formats.
  localparam int DEST_W    = 12;
  localparam int INT_W     = 14;
  localparam int FIDX_W    = 10;

  // Far-point limit on a source coordinate, and the bits it needs.
  localparam int COORD_LIMIT = 5000;
  localparam int LIMIT_W     = 13;

  typedef logic signed [CFG_W-1:0] coef_t;

  // Register index codes.
  typedef enum logic [IDX_W-1:0] {
    CFG_H00 = 4'd0,
    CFG_H01 = 4'd1,
    CFG_H02 = 4'd2,
    CFG_H10 = 4'd3,
    CFG_H11 = 4'd4,
    CFG_H12 = 4'd5,
    CFG_H20 = 4'd6,
    CFG_H21 = 4'd7
  } cfg_idx_e;

endpackage

// ----- src/homography_remap_coordinate_generator.sv -----
// ----------------------------------------------------------------------------
// homography_remap_coordinate_generator: inverse perspective remap entries
// Maps a destination pixel through the inverse homography and produces the
// integer source position and a packed 1/2^FRAC_BITS interpolation index.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid_i / in_stall_o) carries one destination pixel
//   (dest_x_i, dest_y_i) per beat. Output channel (out_valid_o / out_stall_i)
//   carries one remap entry per beat, in input order.
// - Configuration channel (cfg_valid_i / cfg_ready_o) writes one coefficient
//   per beat; cfg_ready_o is always high and indexes above 7 are ignored.
//   Coefficients are to be written only while the pipeline is empty; the block itself does not enforce this.
// - Throughput is one beat per clock while the output is not stalled. Each
//   beat passes the multiply, sum, magnitude, limit scaling and limit compare
//   stages, the pipelined restoring divider and the output register.
// - When the receiver stalls a valid output, the whole pipeline freezes and
//   in_stall_o is raised in the same cycle; nothing is dropped or repeated.
// - Reset empties the pipeline and loads the identity homography.
// ----------------------------------------------------------------------------
module homography_remap_coordinate_generator #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hrcg_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [hrcg_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hrcg_pkg::DEST_W-1:0]        dest_x_i,
  input  logic [hrcg_pkg::DEST_W-1:0]        dest_y_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [hrcg_pkg::INT_W-1:0]  src_x_int_o,
  output logic signed [hrcg_pkg::INT_W-1:0]  src_y_int_o,
  output logic [hrcg_pkg::FIDX_W-1:0]        frac_index_o
);
  import hrcg_pkg::*;

  // Derived widths.
  localparam int XB  = (COORD_BITS < DEST_W) ? COORD_BITS : DEST_W;
  localparam int CW  = XB + 1;
  localparam int PHW = CFG_HALF + CW;
  localparam int PLW = CFG_HALF + 1 + CW;
  localparam int NW  = CFG_W + 2 + XB;
  localparam int QB  = LIMIT_W + 1 + FRAC_BITS;
  localparam int RW  = NW + QB;
  localparam int DLW = NW + LIMIT_W;
  localparam int TW  = QB + 1;

  // Global advance: the pipeline moves unless a finished beat is stalled.
  logic en;
  logic out_valid_q;
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // Coefficient registers.
  coef_t h_q [NUM_REGS];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= CFG_W'(ONE_Q24);
      h_q[1] <= '0;
      h_q[2] <= '0;
      h_q[3] <= '0;
      h_q[4] <= CFG_W'(ONE_Q24);
      h_q[5] <= '0;
      h_q[6] <= '0;
      h_q[7] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_H00: h_q[0] <= cfg_data_i;
        CFG_H01: h_q[1] <= cfg_data_i;
        CFG_H02: h_q[2] <= cfg_data_i;
        CFG_H10: h_q[3] <= cfg_data_i;
        CFG_H11: h_q[4] <= cfg_data_i;
        CFG_H12: h_q[5] <= cfg_data_i;
        CFG_H20: h_q[6] <= cfg_data_i;
        CFG_H21: h_q[7] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: split each coefficient into halves and form partial products.
  // Product slots: 0 h00*x, 1 h01*y, 2 h10*x, 3 h11*y, 4 h20*x, 5 h21*y.
  logic signed [CW-1:0]  xs, ys;
  logic signed [PHW-1:0] ph_d [6];
  logic signed [PLW-1:0] pl_d [6];
  logic signed [PHW-1:0] ph_q [6];
  logic signed [PLW-1:0] pl_q [6];
  logic                  v1_q;

  assign xs = $signed({1'b0, dest_x_i[XB-1:0]});
  assign ys = $signed({1'b0, dest_y_i[XB-1:0]});

  always_comb begin
    coef_t c;
    for (int k = 0; k < 6; k++) begin
      c = h_q[(k < 2) ? k : ((k < 4) ? k + 1 : k + 2)];
      ph_d[k] = PHW'($signed(c[CFG_W-1:CFG_HALF]) * ((k % 2 == 0) ? xs : ys));
      pl_d[k] = PLW'($signed({1'b0, c[CFG_HALF-1:0]}) * ((k % 2 == 0) ? xs : ys));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
  end

  // Stage 2: assemble the two numerators and the denominator.
  logic signed [NW-1:0] full [6];
  logic signed [NW-1:0] nx_q, ny_q, w_q;
  logic                 v2_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      full[k] = (NW'(ph_q[k]) <<< CFG_HALF) + NW'(pl_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= full[0] + full[1] + NW'(h_q[2]);
      ny_q <= full[2] + full[3] + NW'(h_q[5]);
      w_q  <= full[4] + full[5] + NW'(ONE_Q24);
    end
  end

  // Stage 3: magnitudes, result signs and the zero-denominator case.
  logic [NW-1:0] ax3_q, ay3_q, d3_q;
  logic          negx3_q, negy3_q, wz3_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax3_q   <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      ay3_q   <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      d3_q    <= w_q[NW-1] ? NW'(-w_q) : NW'(w_q);
      negx3_q <= nx_q[NW-1] ^ w_q[NW-1];
      negy3_q <= ny_q[NW-1] ^ w_q[NW-1];
      wz3_q   <= (w_q == '0);
    end
  end

  // Stage 4: scale the denominator by the far-point limit.
  logic [NW-1:0]  ax4_q, ay4_q, d4_q;
  logic [DLW-1:0] dl4_q;
  logic           negx4_q, negy4_q, wz4_q, v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      d4_q    <= d3_q;
      dl4_q   <= DLW'(d3_q) * DLW'(COORD_LIMIT);
      negx4_q <= negx3_q;
      negy4_q <= negy3_q;
      wz4_q   <= wz3_q;
    end
  end

  // Divider stage arrays; entry 0 is loaded by stage 5, entry QB is the last.
  logic [RW-1:0] rx_q [QB+1];
  logic [RW-1:0] ry_q [QB+1];
  logic [QB-1:0] qx_q [QB+1];
  logic [QB-1:0] qy_q [QB+1];
  logic [NW-1:0] dd_q [QB+1];
  logic          clx_q [QB+1];
  logic          cly_q [QB+1];
  logic          ngx_q [QB+1];
  logic          ngy_q [QB+1];
  logic          wz_q  [QB+1];
  logic          vd_q  [QB+1];

  // Stage 5: far-point compare and divider preload with the fraction shift.
  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q[0]  <= RW'(ax4_q) << (FRAC_BITS + 1);
      ry_q[0]  <= RW'(ay4_q) << (FRAC_BITS + 1);
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      dd_q[0]  <= d4_q;
      clx_q[0] <= (DLW'(ax4_q) > dl4_q);
      cly_q[0] <= (DLW'(ay4_q) > dl4_q);
      ngx_q[0] <= negx4_q;
      ngy_q[0] <= negy4_q;
      wz_q[0]  <= wz4_q;
    end
  end

  // Restoring divider: one quotient bit per stage, most significant first.
  for (genvar i = 0; i < QB; i++) begin : g_div
    localparam int K = QB - 1 - i;
    logic [RW-1:0] tx, ty;
    logic          gex, gey;

    assign tx  = RW'(dd_q[i]) << K;
    assign ty  = tx;
    assign gex = (rx_q[i] >= tx);
    assign gey = (ry_q[i] >= ty);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[i+1]    <= gex ? rx_q[i] - tx : rx_q[i];
        ry_q[i+1]    <= gey ? ry_q[i] - ty : ry_q[i];
        qx_q[i+1]    <= qx_q[i] | (QB'(gex) << K);
        qy_q[i+1]    <= qy_q[i] | (QB'(gey) << K);
        dd_q[i+1]    <= dd_q[i];
        clx_q[i+1]   <= clx_q[i];
        cly_q[i+1]   <= cly_q[i];
        ngx_q[i+1]   <= ngx_q[i];
        ngy_q[i+1]   <= ngy_q[i];
        wz_q[i+1]    <= wz_q[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[i+1] <= 1'b0;
      end else if (en) begin
        vd_q[i+1] <= vd_q[i];
      end
    end
  end

  // Output stage: round to the fraction grid, apply special cases, split.
  logic [QB:0]          sx, sy;
  logic [QB-1:0]        mx, my;
  logic signed [TW-1:0] tvx, tvy;
  logic signed [TW-1:0] tlim;
  logic [FIDX_W+2*FRAC_BITS-1:0] fcat;

  assign tlim = TW'(COORD_LIMIT) <<< FRAC_BITS;

  always_comb begin
    // Ties go up for positive values; a negative value rounds its magnitude
    // up only when the division left a remainder.
    sx = {1'b0, qx_q[QB]} + (ngx_q[QB] ? (QB+1)'(rx_q[QB] != '0) : (QB+1)'(1));
    sy = {1'b0, qy_q[QB]} + (ngy_q[QB] ? (QB+1)'(ry_q[QB] != '0) : (QB+1)'(1));
    mx = sx[QB:1];
    my = sy[QB:1];
    priority if (wz_q[QB]) begin
      tvx = '0;
    end else if (clx_q[QB]) begin
      tvx = tlim;
    end else if (ngx_q[QB]) begin
      tvx = -$signed({1'b0, mx});
    end else begin
      tvx = $signed({1'b0, mx});
    end
    priority if (wz_q[QB]) begin
      tvy = '0;
    end else if (cly_q[QB]) begin
      tvy = tlim;
    end else if (ngy_q[QB]) begin
      tvy = -$signed({1'b0, my});
    end else begin
      tvy = $signed({1'b0, my});
    end
    fcat = {{FIDX_W{1'b0}}, tvy[FRAC_BITS-1:0], tvx[FRAC_BITS-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      src_x_int_o  <= tvx[FRAC_BITS+INT_W-1:FRAC_BITS];
      src_y_int_o  <= tvy[FRAC_BITS+INT_W-1:FRAC_BITS];
      frac_index_o <= fcat[FIDX_W-1:0];
    end
  end

  // Valid bits of the front stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      vd_q[0]     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      vd_q[0]     <= v4_q;
      out_valid_q <= vd_q[QB];
    end
  end

`ifndef SYNTH
  // Source coordinates never leave the far-point window.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (src_x_int_o >= -14'sd5000) && (src_x_int_o <= 14'sd5000) &&
                    (src_y_int_o >= -14'sd5000) && (src_y_int_o <= 14'sd5000))
    else $error("remap entry outside the coordinate limit");

  // An unclamped x quotient stays within the limit on the grid with one extra fraction bit.
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q[QB] && !wz_q[QB] && !clx_q[QB]) |->
      (TW'(qx_q[QB]) <= (TW'(COORD_LIMIT) << (FRAC_BITS + 1))))
    else $error("x quotient exceeds the limit");

  // The divider leaves a remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vd_q[QB] && !wz_q[QB] && !clx_q[QB] && !cly_q[QB]) |->
      (rx_q[QB] < RW'(dd_q[QB])) && (ry_q[QB] < RW'(dd_q[QB])))
    else $error("divider remainder not reduced");

  // The pipeline only freezes while a finished beat is held, and then holds.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o ##1 $stable(v1_q))
    else $error("pipeline frozen without a held beat");
`endif

endmodule
